@@ rtl/core/gbrp_pkg.sv @@
// ----------------------------------------------------------------------------
// gbrp_pkg
// Shared types, constants and battery decode functions of the game pad
// battery report parser.
// ----------------------------------------------------------------------------
package gbrp_pkg;

  // Report length limit; the byte index saturates here
  localparam int MAX_REPORT_BYTES = 1024;
  localparam int CNT_W            = $clog2(MAX_REPORT_BYTES + 1);

  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int PERCENT_W = 7;
  localparam int OFS_W     = 6;
  localparam int OUT_TDATA_W = 8;

  // Report layouts
  localparam logic [MODE_W-1:0] LAYOUT_PAD_A = 2'd0;
  localparam logic [MODE_W-1:0] LAYOUT_PAD_B = 2'd1;
  localparam logic [MODE_W-1:0] LAYOUT_PAD_C = 2'd2;

  // Report ids
  localparam logic [BYTE_W-1:0] ID_BASIC      = 8'h01;
  localparam logic [BYTE_W-1:0] ID_BT_FIRST   = 8'h11;
  localparam logic [BYTE_W-1:0] ID_BT_LAST    = 8'h19;
  localparam logic [BYTE_W-1:0] ID_BT_EXT     = 8'h31;
  localparam logic [BYTE_W-1:0] ID_FULL_STATE = 8'h30;

  // Battery byte offsets; zero means the report carries none
  localparam logic [OFS_W-1:0] OFS_NONE    = 6'd0;
  localparam logic [OFS_W-1:0] OFS_A_USB   = 6'd30;
  localparam logic [OFS_W-1:0] OFS_A_BT    = 6'd32;
  localparam logic [OFS_W-1:0] OFS_B_USB   = 6'd53;
  localparam logic [OFS_W-1:0] OFS_B_BT    = 6'd54;
  localparam logic [OFS_W-1:0] OFS_C       = 6'd2;

  localparam logic [CNT_W-1:0] EXT_START   = CNT_W'(10);
  localparam logic [CNT_W-1:0] USB_B_LEN   = CNT_W'(64);
  localparam logic [PERCENT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PERCENT_W-1:0] PCT_NONE = 7'd0;

  // One input word after the input register
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] report_byte;
    logic              last_byte;
  } item_t;

  // Battery offset for a layout and report id
  function automatic logic [OFS_W-1:0] battery_offset(
    input logic [MODE_W-1:0] layout,
    input logic [BYTE_W-1:0] id
  );
    logic [OFS_W-1:0] ofs;
    ofs = OFS_NONE;
    case (layout)
      LAYOUT_PAD_A: begin
        if (id == ID_BASIC) ofs = OFS_A_USB;
        else if (id >= ID_BT_FIRST && id <= ID_BT_LAST) ofs = OFS_A_BT;
      end
      LAYOUT_PAD_B: begin
        if (id == ID_BASIC) ofs = OFS_B_USB;
        else if (id == ID_BT_EXT) ofs = OFS_B_BT;
      end
      LAYOUT_PAD_C: begin
        if (id == ID_FULL_STATE || id == ID_BT_EXT) ofs = OFS_C;
      end
      default: ofs = OFS_NONE;
    endcase
    return ofs;
  endfunction

  // Level in tens with a half step, clamped to full
  function automatic logic [PERCENT_W-1:0] level_percent(input logic [3:0] level);
    logic [7:0] v;
    v = {4'd0, level} * 8'd10 + 8'd5;
    return (v > 8'd100) ? PCT_FULL : v[PERCENT_W-1:0];
  endfunction

  // Battery percent from the captured report state
  function automatic logic [PERCENT_W-1:0] evaluate(
    input logic [MODE_W-1:0] layout,
    input logic [BYTE_W-1:0] id,
    input logic [BYTE_W-1:0] raw,
    input logic              captured,
    input logic              ext_seen,
    input logic              hid_bit,
    input logic              len_is_64
  );
    logic [PERCENT_W-1:0] pct;
    logic [7:0]           scaled;
    pct    = PCT_NONE;
    scaled = {5'd0, raw[7:5]} * 8'd25;
    if (battery_offset(layout, id) != OFS_NONE && captured) begin
      case (layout)
        LAYOUT_PAD_A: begin
          if (id == ID_BASIC && !ext_seen) pct = PCT_NONE;
          else if (id != ID_BASIC && !hid_bit) pct = PCT_NONE;
          else if (raw[4] && raw[3:0] > 4'd11) pct = PCT_NONE;
          else pct = level_percent(raw[3:0]);
        end
        LAYOUT_PAD_B: begin
          if (id == ID_BASIC && !len_is_64) pct = PCT_NONE;
          else if (raw[7:4] == 4'd2) pct = PCT_FULL;
          else if (raw[7:4] > 4'd1) pct = PCT_NONE;
          else pct = level_percent(raw[3:0]);
        end
        LAYOUT_PAD_C: begin
          if (scaled == 8'd0) pct = 7'd1;
          else if (scaled > 8'd100) pct = PCT_FULL;
          else pct = scaled[PERCENT_W-1:0];
        end
        default: pct = PCT_NONE;
      endcase
    end
    return pct;
  endfunction

endpackage

@@ rtl/core/gamepad_battery_report_parser.sv @@
// ----------------------------------------------------------------------------
// gamepad_battery_report_parser
// Parses HID game pad input reports one byte per word and reports battery.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one report byte per word on in_tdata, report id first,
//   in_tuser carries the layout (sampled on the first byte), in_tlast marks
//   the final byte of the report buffer.
//   Result channel: one word per report, sent for the in_tlast word only;
//   out_tdata[6:0] is the battery percent 0..100, 0 meaning unknown.
//   Path: the last byte passes the input register, then the result register.
//   Throughput: one byte per cycle, set by the single-pass parse stage, while no
//   last byte waits for the result slot; the input register takes a new byte
//   while a result still waits downstream.
//   Stall: while out_tready is low the result holds; a further last byte
//   waits in the input register and in_tready drops until the slot frees.
//   Reset: rst_n low clears both registers and all report state; the next
//   accepted byte starts a new report. The byte index saturates at
//   MAX_REPORT_BYTES; further bytes change no state until the last byte.
// ----------------------------------------------------------------------------
module gamepad_battery_report_parser import gbrp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] report_byte
  input  logic [MODE_W-1:0]      in_tuser,   // [1:0] mode
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [6:0] battery_percent, [7] zero
);

  logic                 s1_valid;
  item_t                s1_item;
  logic                 s1_take;
  logic                 res_free;
  logic                 res_load;
  logic [PERCENT_W-1:0] res_percent;

  gbrp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take)
  );

  gbrp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .s1_take     (s1_take),
    .res_free    (res_free),
    .res_load    (res_load),
    .res_percent (res_percent)
  );

  gbrp_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_load    (res_load),
    .res_percent (res_percent),
    .res_free    (res_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ rtl/core/gbrp_in_stage.sv @@
// ----------------------------------------------------------------------------
// gbrp_in_stage
// Input register: holds one report word until the parse stage takes it.
// ----------------------------------------------------------------------------
module gbrp_in_stage import gbrp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic [MODE_W-1:0] in_tuser,
  input  logic              in_tlast,
  output logic              s1_valid,
  output item_t             s1_item,
  input  logic              s1_take
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Accept when empty or when the held word leaves this cycle
  assign in_tready = !valid_r || s1_take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode        <= in_tuser;
      item_r.report_byte <= in_tdata;
      item_r.last_byte   <= in_tlast;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

@@ rtl/core/gbrp_parse.sv @@
// ----------------------------------------------------------------------------
// gbrp_parse
// Report state: byte index, id, status bits and battery byte; computes the
// percent on the last byte of a report and clears for the next one.
// ----------------------------------------------------------------------------
module gbrp_parse import gbrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  item_t                s1_item,
  output logic                 s1_take,
  input  logic                 res_free,
  output logic                 res_load,
  output logic [PERCENT_W-1:0] res_percent
);

  logic [CNT_W-1:0]  byte_count_r,  byte_count_nxt;
  logic [MODE_W-1:0] layout_r,      layout_nxt;
  logic [BYTE_W-1:0] ident_r,       ident_nxt;
  logic              hid_bit_r,     hid_bit_nxt;
  logic              ext_seen_r,    ext_seen_nxt;
  logic [BYTE_W-1:0] raw_r,         raw_nxt;
  logic              captured_r,    captured_nxt;
  logic              open_slot;
  logic [OFS_W-1:0]  cur_ofs;

  // Non-last words always move on; a last word waits for the result slot
  assign s1_take  = s1_valid && (!s1_item.last_byte || res_free);
  assign res_load = s1_take && s1_item.last_byte;

  assign open_slot = byte_count_r < CNT_W'(MAX_REPORT_BYTES);
  assign cur_ofs   = battery_offset(layout_r, ident_r);

  // Fold the current byte into the report state
  always_comb begin
    byte_count_nxt = byte_count_r;
    layout_nxt     = layout_r;
    ident_nxt      = ident_r;
    hid_bit_nxt    = hid_bit_r;
    ext_seen_nxt   = ext_seen_r;
    raw_nxt        = raw_r;
    captured_nxt   = captured_r;
    if (open_slot) begin
      if (byte_count_r == '0) begin
        layout_nxt = s1_item.mode;
        ident_nxt  = s1_item.report_byte;
      end
      if (byte_count_r == CNT_W'(1)) hid_bit_nxt = s1_item.report_byte[7];
      if (byte_count_r >= EXT_START && s1_item.report_byte != '0) ext_seen_nxt = 1'b1;
      if (byte_count_r != '0 && byte_count_r == CNT_W'(cur_ofs)) begin
        raw_nxt      = s1_item.report_byte;
        captured_nxt = 1'b1;
      end
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end
  end

  assign res_percent = evaluate(layout_nxt, ident_nxt, raw_nxt, captured_nxt,
                                ext_seen_nxt, hid_bit_nxt, byte_count_nxt == USB_B_LEN);

  // Advance the state; clear it at the end of a report
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      byte_count_r <= '0;
      layout_r     <= '0;
      ident_r      <= '0;
      hid_bit_r    <= 1'b0;
      ext_seen_r   <= 1'b0;
      raw_r        <= '0;
      captured_r   <= 1'b0;
    end else if (s1_take) begin
      byte_count_r <= byte_count_nxt;
      layout_r     <= layout_nxt;
      ident_r      <= ident_nxt;
      hid_bit_r    <= hid_bit_nxt;
      ext_seen_r   <= ext_seen_nxt;
      raw_r        <= raw_nxt;
      captured_r   <= captured_nxt;
    end
  end

endmodule

@@ rtl/core/gbrp_out_stage.sv @@
// ----------------------------------------------------------------------------
// gbrp_out_stage
// Result register: holds one battery percent word until the receiver takes it.
// ----------------------------------------------------------------------------
module gbrp_out_stage import gbrp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  logic [PERCENT_W-1:0]   res_percent,
  output logic                   res_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [PERCENT_W-1:0] percent_r;

  // Slot frees when empty or when the held word is taken now
  assign res_free  = !valid_r || out_tready;
  assign valid_nxt = res_load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the percent while stalled
  always_ff @(posedge clk) begin
    if (res_load) begin
      percent_r <= res_percent;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - PERCENT_W){1'b0}}, percent_r};

endmodule

@@ rtl/core/gbrp_checker.sv @@
// ----------------------------------------------------------------------------
// gbrp_checker
// Port-level checks of the battery report parser, bound to the top level.
// ----------------------------------------------------------------------------
module gbrp_checker import gbrp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word dropped or changed");

  // Percent stays in range with a clear pad bit
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] == 1'b0 && out_tdata[6:0] <= 7'd100)
    else $error("battery percent out of range");

  // A fresh result must follow an accepted last byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result word without a last byte");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind gamepad_battery_report_parser gbrp_checker u_gbrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/tb_gamepad_battery_report_parser.sv @@
// ----------------------------------------------------------------------------
// tb_gamepad_battery_report_parser
// Self-checking bench for the battery report parser. Whole reports are sent
// one byte per word and a local parse of each accepted word predicts the
// battery percent. Every result word is compared with the oldest pending
// percent. Directed reports cover each layout, the id and length checks,
// the level mappings, short and single-byte reports and the unused layout.
// They are followed by a receiver hold-off that backs up the input, then
// random reports with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_gamepad_battery_report_parser;
  import gbrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BYTE_W-1:0] byte_list_t[$];

  localparam logic [MODE_W-1:0] LAYOUT_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] ID_OTHER_LOW  = 8'h10;
  localparam logic [BYTE_W-1:0] ID_OTHER_HIGH = 8'h1A;
  localparam logic [BYTE_W-1:0] ID_OTHER_C    = 8'h32;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_BYTES  = 150;
  localparam int RANDOM_REPORTS = 6;
  localparam int MAX_PRINTED   = 40;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;   // [7:0] report_byte
  logic [MODE_W-1:0]      in_tuser;   // [1:0] mode
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [6:0] battery_percent, [7] zero

  gamepad_battery_report_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pending battery percents, oldest first
  logic [PERCENT_W-1:0] percent_due_q[$];
  int mismatches = 0;
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_request  = 1'b0;

  // Local copy of the report parse state
  logic [CNT_W-1:0]  seen_count;
  logic [MODE_W-1:0] seen_layout;
  logic [BYTE_W-1:0] seen_ident;
  logic              seen_hid_bit;
  logic              seen_extended;
  logic [BYTE_W-1:0] seen_battery;
  logic              seen_captured;

  task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] got,
                                 input logic [OUT_TDATA_W-1:0] want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch: %s, got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Battery byte position for a layout and report id; zero means none
  function automatic int battery_pos(input logic [MODE_W-1:0] lay,
                                     input logic [BYTE_W-1:0] id);
    case (lay)
      LAYOUT_PAD_A: begin
        if (id == ID_BASIC) return int'(OFS_A_USB);
        if (id >= ID_BT_FIRST && id <= ID_BT_LAST) return int'(OFS_A_BT);
      end
      LAYOUT_PAD_B: begin
        if (id == ID_BASIC) return int'(OFS_B_USB);
        if (id == ID_BT_EXT) return int'(OFS_B_BT);
      end
      LAYOUT_PAD_C: begin
        if (id == ID_FULL_STATE || id == ID_BT_EXT) return int'(OFS_C);
      end
      default: return 0;
    endcase
    return 0;
  endfunction

  function automatic logic [PERCENT_W-1:0] clamp_full(input int v);
    return (v > 100) ? PCT_FULL : PERCENT_W'(v);
  endfunction

  // Percent from the finished report
  function automatic logic [PERCENT_W-1:0] decode_percent();
    int level;
    int scaled;
    level  = int'(seen_battery[3:0]);
    scaled = int'(seen_battery[7:5]) * 25;
    if (battery_pos(seen_layout, seen_ident) == 0 || !seen_captured) return PCT_NONE;
    case (seen_layout)
      LAYOUT_PAD_A: begin
        if (seen_ident == ID_BASIC && !seen_extended) return PCT_NONE;
        if (seen_ident != ID_BASIC && !seen_hid_bit) return PCT_NONE;
        if (seen_battery[4] && level > 11) return PCT_NONE;
        return clamp_full(level * 10 + 5);
      end
      LAYOUT_PAD_B: begin
        if (seen_ident == ID_BASIC && seen_count != CNT_W'(64)) return PCT_NONE;
        if (seen_battery[7:4] == 4'd2) return PCT_FULL;
        if (seen_battery[7:4] > 4'd1) return PCT_NONE;
        return clamp_full(level * 10 + 5);
      end
      LAYOUT_PAD_C: begin
        if (scaled == 0) return PERCENT_W'(1);
        return clamp_full(scaled);
      end
      default: return PCT_NONE;
    endcase
  endfunction

  function automatic void clear_parse();
    seen_count    = '0;
    seen_layout   = '0;
    seen_ident    = '0;
    seen_hid_bit  = 1'b0;
    seen_extended = 1'b0;
    seen_battery  = '0;
    seen_captured = 1'b0;
  endfunction

  // Advance the local parse by one accepted word
  function automatic void track_byte(input logic [MODE_W-1:0] mode,
                                     input logic [BYTE_W-1:0] b, input logic is_last);
    int idx;
    if (seen_count < CNT_W'(MAX_REPORT_BYTES)) begin
      idx = int'(seen_count);
      if (idx == 0) begin
        seen_layout = mode;
        seen_ident  = b;
      end
      if (idx == 1) seen_hid_bit = b[7];
      if (idx >= 10 && b != 0) seen_extended = 1'b1;
      if (idx != 0 && idx == battery_pos(seen_layout, seen_ident)) begin
        seen_battery  = b;
        seen_captured = 1'b1;
      end
      seen_count = CNT_W'(idx + 1);
    end
    if (is_last) begin
      percent_due_q.push_back(decode_percent());
      clear_parse();
    end
  endfunction

  // Offer one word and wait for its handshake; valid stays high afterwards
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b,
                           input logic is_last);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mode;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_byte(mode, b, is_last);
  endtask

  // Build one report around a battery byte and send it; tail_quiet zeroes
  // every byte from index 10 on except the battery byte
  task automatic send_report(input logic [MODE_W-1:0] lay, input logic [BYTE_W-1:0] id,
                             input int len, input logic [BYTE_W-1:0] bat,
                             input logic hid, input logic tail_quiet);
    byte_list_t bytes;
    logic [BYTE_W-1:0] b;
    int pos;
    pos = battery_pos(lay, id);
    for (int i = 0; i < len; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (i == 0) b = id;
      else if (i == 1) b[7] = hid;
      if (tail_quiet && i >= 10) b = '0;
      if (i != 0 && i == pos) b = bat;
      bytes.push_back(b);
    end
    // layout matters only on the first word, so the others carry noise
    foreach (bytes[i])
      send_word((i == 0) ? lay : MODE_W'($urandom_range(0, 3)), bytes[i],
                i == bytes.size() - 1);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (percent_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // First layout: both id kinds, charging, clamp, missing flags, short report
  task automatic test_pad_a();
    send_report(LAYOUT_PAD_A, ID_BASIC, 33, 8'h0B, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BASIC, 31, 8'h1C, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BASIC, 35, 8'h1B, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BASIC, 33, 8'hEF, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BASIC, 33, 8'h00, 1'b1, 1'b1);
    send_report(LAYOUT_PAD_A, ID_BASIC, 33, 8'h03, 1'b0, 1'b1);
    send_report(LAYOUT_PAD_A, ID_BT_FIRST, 33, 8'h07, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BT_LAST, 34, 8'h07, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BT_LAST, 34, 8'hFF, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_OTHER_LOW, 12, 8'h05, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_OTHER_HIGH, 12, 8'h05, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_A, ID_BASIC, 30, 8'h05, 1'b1, 1'b0);
  endtask

  // Second layout: exact length on the wired id, status codes, clamp
  task automatic test_pad_b();
    send_report(LAYOUT_PAD_B, ID_BASIC, 64, 8'h25, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BASIC, 64, 8'h03, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BASIC, 65, 8'h03, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BASIC, 63, 8'h03, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BT_EXT, 56, 8'h13, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BT_EXT, 55, 8'h0F, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BT_EXT, 56, 8'h35, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_B, ID_BT_EXT, 54, 8'h13, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_B, ID_FULL_STATE, 64, 8'h13, 1'b1, 1'b0);
  endtask

  // Third layout: 3-bit scale, zero maps to one, clamp, short reports
  task automatic test_pad_c();
    send_report(LAYOUT_PAD_C, ID_FULL_STATE, 3, 8'h00, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_C, ID_FULL_STATE, 3, 8'hE0, 1'b1, 1'b0);
    send_report(LAYOUT_PAD_C, ID_BT_EXT, 12, 8'h80, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_C, ID_BT_EXT, 4, 8'h7F, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_C, ID_OTHER_C, 8, 8'hA0, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_C, ID_FULL_STATE, 2, 8'hA0, 1'b0, 1'b0);
    send_report(LAYOUT_PAD_C, ID_FULL_STATE, 1, 8'hA0, 1'b0, 1'b0);
  endtask

  // Unused layout code always gives unknown
  task automatic test_unused_layout();
    send_report(LAYOUT_UNUSED, ID_BASIC, 40, 8'h05, 1'b1, 1'b0);
    send_report(LAYOUT_UNUSED, ID_FULL_STATE, 3, 8'hE0, 1'b1, 1'b0);
  endtask

  // Hold the receiver off while short reports keep coming
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++)
      send_report(LAYOUT_PAD_C, ID_FULL_STATE, $urandom_range(1, 3),
                  BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
    sender_gaps = 1'b1;
    wait_results();
  endtask

  // Random reports, mostly well formed with random content
  task automatic test_random_reports();
    int sent_bytes;
    int reports;
    int len;
    int pos;
    logic [MODE_W-1:0] lay;
    logic [BYTE_W-1:0] id;
    sent_bytes = 0;
    reports    = 0;
    while (sent_bytes < RANDOM_BYTES || reports < RANDOM_REPORTS) begin
      sender_gaps   = ($urandom_range(0, 4) != 0);
      receiver_gaps = ($urandom_range(0, 4) != 0);
      lay = MODE_W'($urandom_range(0, 2));
      case (lay)
        LAYOUT_PAD_A: id = $urandom_range(0, 1) ? ID_BASIC
                           : BYTE_W'($urandom_range(ID_BT_FIRST, ID_BT_LAST));
        LAYOUT_PAD_B: id = $urandom_range(0, 1) ? ID_BASIC : ID_BT_EXT;
        default:      id = $urandom_range(0, 1) ? ID_FULL_STATE : ID_BT_EXT;
      endcase
      pos = battery_pos(lay, id);
      len = pos + $urandom_range(1, 10);
      if (lay == LAYOUT_PAD_B && id == ID_BASIC && $urandom_range(0, 1)) len = 64;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, pos);
      if ($urandom_range(0, 6) == 0) begin
        lay = MODE_W'($urandom_range(0, 3));
        id  = BYTE_W'($urandom_range(0, 255));
        len = $urandom_range(1, 70);
      end
      send_report(lay, id, len, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 4) == 0);
      sent_bytes += len;
      reports++;
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Receiver: long hold on request, else random stalls
  int hold_left  = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (receiver_gaps && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  // Compare each result word with the oldest pending percent
  always @(posedge clk) begin : check_result
    logic [PERCENT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (percent_due_q.size() == 0) begin
        report_mismatch("result word with none pending", out_tdata, '0);
      end else begin
        want = percent_due_q.pop_front();
        if (out_tdata !== {1'b0, want})
          report_mismatch("battery_percent", out_tdata, {1'b0, want});
      end
    end
  end

  // Bound the run
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gamepad_battery_report_parser] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    clear_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_pad_a();
    test_pad_b();
    test_pad_c();
    test_unused_layout();
    wait_results();
    test_backpressure();
    test_random_reports();
    wait_results();

    if (mismatches == 0) begin
      $display("[gamepad_battery_report_parser] OK");
    end else begin
      $display("[gamepad_battery_report_parser] ERROR");
    end
    $finish;
  end

endmodule
